[rtl/core/btlv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER TLV parser package
// Shared limits, phase and result codes, and the result record type.
// ----------------------------------------------------------------------------
package btlv_pkg;

    // Limits of the decoder.
    localparam int MAX_TAG_BYTES    = 4;
    localparam int MAX_LENGTH_BYTES = 4;
    localparam int COUNT_WIDTH      = 16;

    localparam int TAG_CNT_W = $clog2(MAX_TAG_BYTES + 1);
    localparam int LEN_CNT_W = $clog2(MAX_LENGTH_BYTES + 1);

    // Depth of the result queue; room for two results is needed per byte.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Parser phases.
    localparam logic [2:0] PH_TAG0 = 3'd0;
    localparam logic [2:0] PH_TAGN = 3'd1;
    localparam logic [2:0] PH_LEN0 = 3'd2;
    localparam logic [2:0] PH_LENN = 3'd3;
    localparam logic [2:0] PH_BODY = 3'd4;
    localparam logic [2:0] PH_ERR  = 3'd5;

    // Result kinds.
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_CONTENT = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_TRUNCATED = 2'd1;
    localparam logic [1:0] ERR_LEN_BYTES = 2'd2;
    localparam logic [1:0] ERR_TAG_LONG  = 2'd3;

    // Tag byte markers.
    localparam logic [4:0] TAG_MULTI   = 5'h1f;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] tag_value;
        logic [2:0]  tag_bytes;
        logic [31:0] content_length;
        logic [7:0]  content_byte;
        logic        content_end;
        logic [15:0] item_count;
        logic [1:0]  error_code;
        logic        last;
    } t_result;

endpackage

[rtl/core/ber_tlv_stream_parser.sv]
`timescale 1ns / 1ps
// Results of a byte are written into the result queue when the byte is transferred.
// Throughput: one byte per cycle; each byte yields up to two results, drained one per cycle
// unless stalled, from a four-entry queue; input stalls while fewer than two slots are free.
// Reset: synchronous, active low; clears the parser state, the item count and the queue pointers.
// ----------------------------------------------------------------------------
// BER TLV stream parser
// Splits a byte stream of BER encoded data into header, content and
// end-of-buffer results, one input byte per cycle while o_stall is low.
// ----------------------------------------------------------------------------
module ber_tlv_stream_parser
    import btlv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input byte channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_buffer,
    // Result channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [31:0] o_tag_value,
    output logic [2:0]  o_tag_bytes,
    output logic [31:0] o_content_length,
    output logic [7:0]  o_content_byte,
    output logic        o_content_end,
    output logic [15:0] o_item_count,
    output logic [1:0]  o_error_code,
    output logic        o_last
);

    // ------------------------------------------------------------------
    // Parser state. It is updated at each accepted input transfer, and
    // the results of that byte are written into the result queue at the
    // same edge.
    // ------------------------------------------------------------------
    logic [2:0]             r_phase,     n_phase;
    logic [31:0]            r_tag_acc,   n_tag_acc;
    logic [TAG_CNT_W-1:0]   r_tag_cnt,   n_tag_cnt;
    logic [31:0]            r_len_acc,   n_len_acc;
    logic [LEN_CNT_W-1:0]   r_len_left,  n_len_left;
    logic [31:0]            r_body_left, n_body_left;
    logic [COUNT_WIDTH-1:0] r_items,     n_items;
    logic [1:0]             r_err,       n_err;

    // Result queue.
    t_result                r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0]      r_wr_ptr,    n_wr_ptr;
    logic [QPTR_W-1:0]      r_rd_ptr,    n_rd_ptr;
    logic [QCNT_W-1:0]      r_count,     n_count;

    logic                   in_xfer;
    logic                   out_xfer;
    logic                   push_a;
    logic                   push_b;
    t_result                res_a;
    t_result                res_b;
    logic                   hdr_go;
    logic [31:0]            hdr_len;
    logic [6:0]             len_field;
    logic [31:0]            tag_cnt_ext;
    logic [31:0]            items_ext;
    logic [LEN_CNT_W-1:0]   len_left_dec;
    logic [31:0]            body_left_dec;
    logic [31:0]            len_acc_sh;
    logic                   count_inc;

    // The queue must have room for the two results a byte can cause.
    assign o_stall  = r_count > QCNT_W'(QUEUE_DEPTH - 2);
    assign in_xfer  = i_valid && !o_stall;
    assign o_valid  = r_count != '0;
    assign out_xfer = o_valid && !i_stall;

    assign len_field     = i_data_byte[6:0];
    assign tag_cnt_ext   = 32'(r_tag_cnt);
    assign len_left_dec  = (r_len_left != '0) ? r_len_left - 1'b1 : r_len_left;
    assign body_left_dec = (r_body_left != '0) ? r_body_left - 32'd1 : r_body_left;
    assign len_acc_sh    = {r_len_acc[23:0], i_data_byte};

    // ------------------------------------------------------------------
    // Byte decode. res_a is the header or content result of the byte,
    // res_b the end-of-buffer result.
    // ------------------------------------------------------------------
    always_comb begin
        n_phase     = r_phase;
        n_tag_acc   = r_tag_acc;
        n_tag_cnt   = r_tag_cnt;
        n_len_acc   = r_len_acc;
        n_len_left  = r_len_left;
        n_body_left = r_body_left;
        n_err       = r_err;
        hdr_go      = 1'b0;
        hdr_len     = '0;
        count_inc   = 1'b0;
        push_a      = 1'b0;
        res_a       = '0;

        unique case (r_phase)
            PH_TAG0: begin
                n_tag_acc = {24'd0, i_data_byte};
                n_tag_cnt = TAG_CNT_W'(1);
                n_phase   = (i_data_byte[4:0] == TAG_MULTI) ? PH_TAGN : PH_LEN0;
            end
            PH_TAGN: begin
                if (r_tag_cnt >= TAG_CNT_W'(MAX_TAG_BYTES)) begin
                    n_err   = ERR_TAG_LONG;
                    n_phase = PH_ERR;
                end else begin
                    n_tag_acc = {r_tag_acc[23:0], i_data_byte};
                    n_tag_cnt = r_tag_cnt + 1'b1;
                    if (!i_data_byte[7]) begin
                        n_phase = PH_LEN0;
                    end
                end
            end
            PH_LEN0: begin
                if (!i_data_byte[7]) begin
                    hdr_go  = 1'b1;
                    hdr_len = {25'd0, len_field};
                end else if (len_field > 7'(MAX_LENGTH_BYTES)) begin
                    n_err   = ERR_LEN_BYTES;
                    n_phase = PH_ERR;
                end else if (len_field == '0) begin
                    hdr_go  = 1'b1;
                    hdr_len = '0;
                end else begin
                    n_len_acc  = '0;
                    n_len_left = LEN_CNT_W'(len_field);
                    n_phase    = PH_LENN;
                end
            end
            PH_LENN: begin
                n_len_acc  = len_acc_sh;
                n_len_left = len_left_dec;
                if (len_left_dec == '0) begin
                    hdr_go  = 1'b1;
                    hdr_len = len_acc_sh;
                end
            end
            PH_BODY: begin
                n_body_left        = body_left_dec;
                push_a             = 1'b1;
                res_a.kind         = KIND_CONTENT;
                res_a.content_byte = i_data_byte;
                res_a.content_end  = (body_left_dec == '0);
                if (body_left_dec == '0) begin
                    count_inc = 1'b1;
                    n_phase   = PH_TAG0;
                end
            end
            default: begin
                // Error latched: bytes are dropped until the buffer ends.
            end
        endcase

        // Header result; an empty item is complete at once.
        if (hdr_go) begin
            push_a               = 1'b1;
            res_a.kind           = KIND_HEADER;
            res_a.tag_value      = r_tag_acc;
            res_a.tag_bytes      = tag_cnt_ext[2:0];
            res_a.content_length = hdr_len;
            if (hdr_len == '0) begin
                count_inc = 1'b1;
                n_phase   = PH_TAG0;
            end else begin
                n_body_left = hdr_len;
                n_phase     = PH_BODY;
            end
        end

        // Saturating item count.
        n_items = r_items;
        if (count_inc && (r_items != '1)) begin
            n_items = r_items + 1'b1;
        end
        items_ext = 32'(n_items);

        // End of buffer: report the count or an error, then start over.
        push_b = i_end_of_buffer;
        res_b  = '0;
        if (n_err != ERR_NONE) begin
            res_b.kind       = KIND_ERROR;
            res_b.error_code = n_err;
        end else if (n_phase == PH_TAG0) begin
            res_b.kind       = KIND_DONE;
            res_b.item_count = items_ext[15:0];
        end else begin
            res_b.kind       = KIND_ERROR;
            res_b.error_code = ERR_TRUNCATED;
        end
        res_b.last = 1'b1;
        res_a.last = !i_end_of_buffer;

        if (i_end_of_buffer) begin
            n_phase     = PH_TAG0;
            n_tag_acc   = '0;
            n_tag_cnt   = '0;
            n_len_acc   = '0;
            n_len_left  = '0;
            n_body_left = '0;
            n_items     = '0;
            n_err       = ERR_NONE;
        end
    end

    // ------------------------------------------------------------------
    // Queue pointers. Up to two entries are written per input transfer,
    // one is read per output transfer.
    // ------------------------------------------------------------------
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (in_xfer) begin
            n_wr_ptr = r_wr_ptr + QPTR_W'(push_a) + QPTR_W'(push_b);
            n_count  = n_count + QCNT_W'(push_a) + QCNT_W'(push_b);
        end
        if (out_xfer) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
            n_count  = n_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TAG0;
            r_tag_acc   <= '0;
            r_tag_cnt   <= '0;
            r_len_acc   <= '0;
            r_len_left  <= '0;
            r_body_left <= '0;
            r_items     <= '0;
            r_err       <= ERR_NONE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
        end else begin
            if (in_xfer) begin
                r_phase     <= n_phase;
                r_tag_acc   <= n_tag_acc;
                r_tag_cnt   <= n_tag_cnt;
                r_len_acc   <= n_len_acc;
                r_len_left  <= n_len_left;
                r_body_left <= n_body_left;
                r_items     <= n_items;
                r_err       <= n_err;
            end
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            if (push_a) begin
                r_queue[r_wr_ptr] <= res_a;
            end
            if (push_b) begin
                r_queue[r_wr_ptr + QPTR_W'(push_a)] <= res_b;
            end
        end
    end

    assign o_kind           = r_queue[r_rd_ptr].kind;
    assign o_tag_value      = r_queue[r_rd_ptr].tag_value;
    assign o_tag_bytes      = r_queue[r_rd_ptr].tag_bytes;
    assign o_content_length = r_queue[r_rd_ptr].content_length;
    assign o_content_byte   = r_queue[r_rd_ptr].content_byte;
    assign o_content_end    = r_queue[r_rd_ptr].content_end;
    assign o_item_count     = r_queue[r_rd_ptr].item_count;
    assign o_error_code     = r_queue[r_rd_ptr].error_code;
    assign o_last           = r_queue[r_rd_ptr].last;

endmodule
